[rtl/sss_pkg.sv]
// Shared types, widths and codes for the swing step sequencer.
package sss_pkg;

    // Table and field widths.
    localparam int MAX_STEPS = 64;
    localparam int POS_W     = 6;
    localparam int CNT_W     = POS_W + 1;
    localparam int SPS_W     = 28;
    localparam int SWING_W   = 8;
    localparam int ACC_W     = 30;
    localparam int LEN_W     = SPS_W + 1;
    localparam int PROD_W    = SPS_W + SWING_W;
    localparam int EXT_W     = PROD_W - 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPS_W;

    localparam logic [CNT_W-1:0] STEPS_MAX = CNT_W'(MAX_STEPS);

    // Reset values of the configuration registers.
    localparam logic [SPS_W-1:0]   SPS_RESET   = SPS_W'(2257920);
    localparam logic [SWING_W-1:0] SWING_RESET = '0;
    localparam logic [CNT_W-1:0]   STEPS_RESET = CNT_W'(16);

    // Held note value that marks silence.
    localparam logic [7:0] NOTE_REST = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWING_AMOUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT       = 2'd2;

    // Request command codes.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_SETPOS = 3'd4;

    // Input request payload.
    typedef struct packed {
        logic [2:0]        command;
        logic [13:0]       sample_count;
        logic [15:0]       random_value;
        logic [5:0]        step_index;
        logic              step_active;
        logic signed [7:0] step_note;
        logic [6:0]        step_velocity;
        logic [16:0]       step_probability;
        logic [7:0]        step_expr_x;
        logic [7:0]        step_expr_y;
        logic [7:0]        step_expr_z;
    } t_seq_in;

    // Result payload.
    typedef struct packed {
        logic              note_started;
        logic signed [7:0] out_note;
        logic [6:0]        out_velocity;
        logic [7:0]        out_expr_x;
        logic [7:0]        out_expr_y;
        logic [7:0]        out_expr_z;
        logic [5:0]        play_position;
        logic              running;
    } t_seq_out;

    // One entry of the step table.
    typedef struct packed {
        logic        active;
        logic [7:0]  note;
        logic [6:0]  velocity;
        logic [16:0] prob;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  ez;
    } t_step_entry;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EVAL,
        S_WRAP,
        S_DONE
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic exec;
        logic eval;
        logic wrap_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_tick;
        logic hit;
        logic wrap_last;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/sss_ctrl.sv]
// Controller state machine that sequences one request at a time.
module sss_ctrl
    import sss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.run_tick) begin
                    o_cmd.prep = 1'b1;
                    n_state    = S_EVAL;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.hit) begin
                    n_state = S_WRAP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRAP: begin
                o_cmd.wrap_step = 1'b1;
                if (i_status.wrap_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A step evaluation always follows the table read and accumulation.
    a_eval_after_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |-> $past(o_cmd.prep))
        else $error("step evaluation without a preceding table read");

endmodule

[rtl/sss_datapath.sv]
// Datapath: configuration, step table, sample counter, wrap unit and result register.
module sss_datapath
    import sss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_seq_in               i_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_seq_out              o_out
);

    // Configuration registers.
    logic [SPS_W-1:0]   r_sps;
    logic [SWING_W-1:0] r_swing;
    logic [CNT_W-1:0]   r_steps;

    // Sequencer state.
    t_seq_in          r_req;
    logic [ACC_W-1:0] r_acc;
    logic [POS_W-1:0] r_position;
    logic             r_playing;
    logic [7:0]       r_held_note;
    logic [6:0]       r_held_vel;
    logic [23:0]      r_held_expr;
    logic             r_started;

    // Tick working registers.
    logic [ACC_W-1:0] r_acc_sum;
    logic [EXT_W-1:0] r_swing_ext;
    t_step_entry      r_rd;
    logic             r_rd_vld;

    // Position wrap unit (restoring remainder, one bit per cycle).
    logic [CNT_W-1:0] r_div;
    logic [CNT_W-1:0] r_rem;
    logic [2:0]       r_wcnt;

    // Step table and its valid bits.
    t_step_entry          r_mem [MAX_STEPS];
    logic [MAX_STEPS-1:0] r_vld;

    logic              r_out_valid;
    t_seq_out          r_out;

    logic [CNT_W-1:0]  w_eff;
    logic [POS_W-1:0]  w_lim;
    logic [ACC_W:0]    w_sum;
    logic [ACC_W-1:0]  w_sat;
    logic [PROD_W-1:0] w_prod;
    logic [LEN_W-1:0]  w_len;
    logic              w_hit;
    logic              w_play;
    t_step_entry       w_entry;
    t_step_entry       w_wr_entry;
    logic              w_wr_en;
    logic [CNT_W-1:0]  w_trial;
    logic [CNT_W-1:0]  n_rem;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps   <= SPS_RESET;
            r_swing <= SWING_RESET;
            r_steps <= STEPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLES_PER_STEP: r_sps   <= i_cfg_data;
                CFG_SWING_AMOUNT:     r_swing <= i_cfg_data[SWING_W-1:0];
                CFG_STEP_COUNT:       r_steps <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective step count clamped to 1..MAX_STEPS, and the last usable position.
    always_comb begin
        if (r_steps == '0) begin
            w_eff = CNT_W'(1);
        end else if (r_steps > STEPS_MAX) begin
            w_eff = STEPS_MAX;
        end else begin
            w_eff = r_steps;
        end
        w_lim = POS_W'(w_eff - CNT_W'(1));
    end

    // Saturating accumulation and the swing extension product.
    assign w_sum  = {1'b0, r_acc} + (ACC_W + 1)'({r_req.sample_count, 8'b0});
    assign w_sat  = w_sum[ACC_W] ? '1 : w_sum[ACC_W-1:0];
    assign w_prod = PROD_W'(r_sps) * PROD_W'(r_swing);

    // Step length, due check and the probability gate.
    assign w_len   = {1'b0, r_sps} + (r_position[0] ? LEN_W'(r_swing_ext) : '0);
    assign w_hit   = r_acc_sum >= ACC_W'(w_len);
    assign w_entry = r_rd_vld ? r_rd : '0;
    assign w_play  = w_entry.active && !w_entry.note[7]
                     && ({1'b0, r_req.random_value} < w_entry.prob);

    // One restoring remainder step for the position wrap.
    assign w_trial = {r_rem[CNT_W-2:0], r_div[CNT_W-1]};
    assign n_rem   = (w_trial >= w_eff) ? (w_trial - w_eff) : w_trial;

    // Entry to store on a write request.
    assign w_wr_en = i_cmd.exec && (r_req.command == CMD_WRITE);
    always_comb begin
        w_wr_entry.active   = r_req.step_active;
        w_wr_entry.note     = r_req.step_note;
        w_wr_entry.velocity = r_req.step_velocity;
        w_wr_entry.prob     = r_req.step_probability;
        w_wr_entry.ex       = r_req.step_expr_x;
        w_wr_entry.ey       = r_req.step_expr_y;
        w_wr_entry.ez       = r_req.step_expr_z;
    end

    // Step table memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_req.step_index] <= w_wr_entry;
        end
        if (i_cmd.prep) begin
            r_rd <= r_mem[r_position];
        end
    end

    // Valid bits stand in for clearing the table at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_vld[r_req.step_index] <= 1'b1;
            end
            if (i_cmd.prep) begin
                r_rd_vld <= r_vld[r_position];
            end
        end
    end

    // Payload registers: the captured request and tick operands.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.prep) begin
            r_acc_sum   <= w_sat;
            r_swing_ext <= w_prod[PROD_W-1:9];
        end
    end

    // Sequencer state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_position  <= '0;
            r_playing   <= 1'b0;
            r_held_note <= NOTE_REST;
            r_held_vel  <= '0;
            r_held_expr <= '0;
            r_started   <= 1'b0;
            r_div       <= '0;
            r_rem       <= '0;
            r_wcnt      <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_started <= 1'b0;
            end

            // Requests other than a running tick.
            if (i_cmd.exec) begin
                unique case (r_req.command)
                    CMD_START: begin
                        r_playing  <= 1'b1;
                        r_position <= '0;
                        r_acc      <= '0;
                    end
                    CMD_STOP: begin
                        r_playing   <= 1'b0;
                        r_position  <= '0;
                        r_held_note <= NOTE_REST;
                    end
                    CMD_SETPOS: begin
                        r_position <= (r_req.step_index > w_lim) ? w_lim : r_req.step_index;
                    end
                    default: begin
                    end
                endcase
            end

            // Tick evaluation: consume one step length when it is due.
            if (i_cmd.eval) begin
                if (w_hit) begin
                    r_acc  <= r_acc_sum - ACC_W'(w_len);
                    r_div  <= CNT_W'(r_position) + CNT_W'(1);
                    r_rem  <= '0;
                    r_wcnt <= 3'(CNT_W - 1);
                    if (w_play) begin
                        r_held_note <= w_entry.note;
                        r_held_vel  <= w_entry.velocity;
                        r_held_expr <= {w_entry.ez, w_entry.ey, w_entry.ex};
                        r_started   <= 1'b1;
                    end else begin
                        r_held_note <= NOTE_REST;
                    end
                end else begin
                    r_acc <= r_acc_sum;
                end
            end

            // Position wrap modulo the effective step count.
            if (i_cmd.wrap_step) begin
                r_rem  <= n_rem;
                r_div  <= {r_div[CNT_W-2:0], 1'b0};
                r_wcnt <= r_wcnt - 3'd1;
                if (r_wcnt == '0) begin
                    r_position <= n_rem[POS_W-1:0];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.note_started  <= r_started;
            r_out.out_note      <= r_held_note;
            r_out.out_velocity  <= r_held_vel;
            r_out.out_expr_x    <= r_held_expr[7:0];
            r_out.out_expr_y    <= r_held_expr[15:8];
            r_out.out_expr_z    <= r_held_expr[23:16];
            r_out.play_position <= r_position;
            r_out.running       <= r_playing;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller.
    assign o_status.run_tick  = (r_req.command == CMD_TICK) && r_playing;
    assign o_status.hit       = w_hit;
    assign o_status.wrap_last = (r_wcnt == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // A finished wrap leaves the position inside the step count in use.
    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wrap_step && o_status.wrap_last |=> CNT_W'(r_position) < $past(w_eff))
        else $error("wrapped position outside the step count");

    // A tick that is not yet due leaves the position alone.
    a_miss_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && !w_hit |=> $stable(r_position))
        else $error("position moved on a tick that was not due");

    // A triggered note is never a rest.
    a_started_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> !r_held_note[7])
        else $error("note started with a negative note value");

endmodule

[rtl/swing_step_sequencer.sv]
// Top level of the swing step sequencer: controller and datapath.
//
// Requests arrive on a valid/ready channel as one t_seq_in word; each request gives
// exactly one result on a valid/ready output channel as one t_seq_out word.
// Configuration registers (samples per step, swing, step count) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight.
// Each request is captured and dispatched; write, start, stop, set position and ticks
// while stopped then load the result; a tick while playing first reads the step table
// and checks whether its step is due, and a tick that advances a step then runs the
// position wrap unit, which resolves one remainder bit per cycle.
// One request is handled at a time: a new request is taken once the previous result
// is loaded into the output register. A request can be accepted while the previous
// result still waits in the output register; if the receiver stalls, the next
// result waits in the controller until the output register frees.
// Reset clears the step table at once through per-entry valid bits, stops playback,
// zeroes the counter and position, and loads the default configuration.
module swing_step_sequencer
    import sss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_seq_in               i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_seq_out              o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Request sequencing.
    sss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic.
    sss_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

[dv/testbench.sv]
// Self-checking testbench for the swing step sequencer: directed table, then random phases.
module testbench
    import sss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int REPORT_LIMIT    = 10;
    localparam int TAIL_CYCLES     = 16;
    localparam longint unsigned ACC_CEILING = 64'h3FFF_FFFF;

    // Command codes the block does not define; they must be ignored.
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    typedef struct {
        t_seq_in  req;
        bit       has_lit;
        t_seq_out lit;
    } t_directed_row;

    typedef struct {
        logic [SPS_W-1:0]   sps;
        logic [SWING_W-1:0] swing;
        logic [CNT_W-1:0]   count;
    } t_setting;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_seq_in               in_req;
    logic                  out_valid;
    logic                  out_ready;
    t_seq_out              out_res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted sequencer state and configuration.
    t_step_entry        step_mem [MAX_STEPS];
    logic [ACC_W-1:0]   acc_q;
    logic [POS_W-1:0]   pos_q;
    logic               playing_q;
    logic [7:0]         held_note_q;
    logic [6:0]         held_vel_q;
    logic [7:0]         held_x_q;
    logic [7:0]         held_y_q;
    logic [7:0]         held_z_q;
    logic [SPS_W-1:0]   sps_q;
    logic [SWING_W-1:0] swing_q;
    logic [CNT_W-1:0]   count_q;

    t_seq_out awaited_results [$];
    bit       calm;
    int       mismatches;
    int       results_seen;
    int       requests_sent;
    int       ticks_sent;
    int       steps_advanced;
    int       notes_started;
    int       cycle_count;

    swing_step_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 2 ns clock.
    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Number of steps before the position wraps, with out-of-range counts clamped.
    function automatic int active_steps();
        if (count_q == 0) return 1;
        if (count_q > STEPS_MAX) return MAX_STEPS;
        return int'(count_q);
    endfunction

    // Applies one request to the predicted state and returns the result it should give.
    function automatic t_seq_out predict_sequencer(input t_seq_in req);
        t_seq_out        res;
        t_step_entry     entry;
        longint unsigned total;
        longint unsigned span;
        logic            started;
        int              lim;
        started = 1'b0;
        case (req.command)
            CMD_TICK: begin
                ticks_sent++;
                if (playing_q) begin
                    total = longint'(acc_q) + (longint'(req.sample_count) << 8);
                    if (total > ACC_CEILING) total = ACC_CEILING;
                    span = sps_q;
                    // Odd steps run longer by half the swing fraction.
                    if (pos_q[0]) span = span + ((span * swing_q) >> 9);
                    if (total >= span) begin
                        total = total - span;
                        entry = step_mem[pos_q];
                        pos_q = POS_W'((int'(pos_q) + 1) % active_steps());
                        steps_advanced++;
                        if (entry.active && !entry.note[7] &&
                            ({1'b0, req.random_value} < entry.prob)) begin
                            started     = 1'b1;
                            held_note_q = entry.note;
                            held_vel_q  = entry.velocity;
                            held_x_q    = entry.ex;
                            held_y_q    = entry.ey;
                            held_z_q    = entry.ez;
                            notes_started++;
                        end else begin
                            held_note_q = NOTE_REST;
                        end
                    end
                    acc_q = ACC_W'(total);
                end
            end
            CMD_WRITE: begin
                step_mem[req.step_index] = {req.step_active, req.step_note, req.step_velocity,
                                            req.step_probability, req.step_expr_x,
                                            req.step_expr_y, req.step_expr_z};
            end
            CMD_START: begin
                playing_q = 1'b1;
                pos_q     = '0;
                acc_q     = '0;
            end
            CMD_STOP: begin
                playing_q   = 1'b0;
                pos_q       = '0;
                held_note_q = NOTE_REST;
            end
            CMD_SETPOS: begin
                lim   = active_steps() - 1;
                pos_q = (int'(req.step_index) > lim) ? POS_W'(lim) : req.step_index;
            end
            default: ;
        endcase
        res.note_started  = started;
        res.out_note      = held_note_q;
        res.out_velocity  = held_vel_q;
        res.out_expr_x    = held_x_q;
        res.out_expr_y    = held_y_q;
        res.out_expr_z    = held_z_q;
        res.play_position = pos_q;
        res.running       = playing_q;
        return res;
    endfunction

    // Request builders for the directed table.
    function automatic t_seq_in tick_req(input int samples, input int rnd);
        t_seq_in req;
        req              = '0;
        req.command      = CMD_TICK;
        req.sample_count = 14'(samples);
        req.random_value = 16'(rnd);
        return req;
    endfunction

    function automatic t_seq_in step_req(input int idx, input bit active, input int note,
                                         input int vel, input int prob, input int x,
                                         input int y, input int z);
        t_seq_in req;
        req                  = '0;
        req.command          = CMD_WRITE;
        req.step_index       = 6'(idx);
        req.step_active      = active;
        req.step_note        = 8'(note);
        req.step_velocity    = 7'(vel);
        req.step_probability = 17'(prob);
        req.step_expr_x      = 8'(x);
        req.step_expr_y      = 8'(y);
        req.step_expr_z      = 8'(z);
        return req;
    endfunction

    function automatic t_seq_in ctl_req(input logic [2:0] cmd, input int idx);
        t_seq_in req;
        req            = '0;
        req.command    = cmd;
        req.step_index = 6'(idx);
        return req;
    endfunction

    function automatic t_seq_out seq_result(input bit started, input int note, input int vel,
                                            input int x, input int y, input int z,
                                            input int pos, input bit run);
        t_seq_out res;
        res.note_started  = started;
        res.out_note      = 8'(note);
        res.out_velocity  = 7'(vel);
        res.out_expr_x    = 8'(x);
        res.out_expr_y    = 8'(y);
        res.out_expr_z    = 8'(z);
        res.play_position = 6'(pos);
        res.running       = run;
        return res;
    endfunction

    // Random request, mostly ticks sized against the current step length.
    function automatic t_seq_in draw_request();
        t_seq_in         req;
        longint unsigned step_samples;
        longint unsigned top;
        int              pick;
        req  = t_seq_in'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            req.command  = CMD_TICK;
            step_samples = sps_q >> 8;
            top          = step_samples * 2 + 1;
            if (top > 16383) top = 16383;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: req.sample_count = 14'($urandom_range(0, int'(top)));
                6, 7, 8:          ;
                default:          req.sample_count = ($urandom_range(0, 1) != 0) ? '1 : '0;
            endcase
            case ($urandom_range(0, 9))
                0:       req.random_value = '0;
                1:       req.random_value = '1;
                default: ;
            endcase
        end else if (pick < 80) begin
            req.command     = CMD_WRITE;
            req.step_active = ($urandom_range(0, 6) != 0);
            if ($urandom_range(0, 3) != 0)
                req.step_index = 6'($urandom_range(0, active_steps() - 1));
            case ($urandom_range(0, 9))
                8:       req.step_note = -8'sd1;
                9:       ;
                default: req.step_note = 8'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 7))
                0:       req.step_probability = '0;
                1, 2:    req.step_probability = 17'd65536;
                3:       ;
                default: req.step_probability = 17'($urandom_range(0, 65535));
            endcase
        end else if (pick < 84) begin
            req.command = CMD_START;
        end else if (pick < 86) begin
            req.command = CMD_STOP;
        end else if (pick < 96) begin
            req.command = CMD_SETPOS;
            if ($urandom_range(0, 2) == 0)
                req.step_index = 6'($urandom_range(0, active_steps() - 1));
        end else begin
            req.command = CMD_SPARE_A + 3'($urandom_range(0, 2));
        end
        return req;
    endfunction

    // Offers one request, waits for acceptance, and queues the result it should give.
    task automatic issue(input t_seq_in req, input bit has_lit, input t_seq_out lit);
        t_seq_out predicted;
        int       gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = predict_sequencer(req);
        awaited_results.push_back(has_lit ? lit : predicted);
        requests_sent++;
    endtask

    // Register writes happen only once every pending result has drained.
    task automatic apply_settings(input t_setting s);
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SAMPLES_PER_STEP;
        cfg_data <= s.sps;
        @(negedge clk);
        cfg_idx  <= CFG_SWING_AMOUNT;
        cfg_data <= CFG_DATA_W'(s.swing);
        @(negedge clk);
        cfg_idx  <= CFG_STEP_COUNT;
        cfg_data <= CFG_DATA_W'(s.count);
        @(negedge clk);
        cfg_we <= 1'b0;
        sps_q   = s.sps;
        swing_q = s.swing;
        count_q = s.count;
    endtask

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: %s expected %0d, got %0d", results_seen, fname,
                         $signed(want), $signed(got));
        end
    endfunction

    // Result checker: every accepted result is compared with the oldest prediction.
    always @(posedge clk) begin
        t_seq_out want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: arrived with no request pending", results_seen);
            end else begin
                want = awaited_results.pop_front();
                check_field("note_started", 32'(want.note_started), 32'(out_res.note_started));
                check_field("out_note", 32'(want.out_note), 32'(out_res.out_note));
                check_field("out_velocity", 32'(want.out_velocity), 32'(out_res.out_velocity));
                check_field("out_expr_x", 32'(want.out_expr_x), 32'(out_res.out_expr_x));
                check_field("out_expr_y", 32'(want.out_expr_y), 32'(out_res.out_expr_y));
                check_field("out_expr_z", 32'(want.out_expr_z), 32'(out_res.out_expr_z));
                check_field("play_position", 32'(want.play_position),
                            32'(out_res.play_position));
                check_field("running", 32'(want.running), 32'(out_res.running));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     awaited_results.size());
            $display("swing_step_sequencer: mismatch");
            $finish;
        end
    end

    // Receiver stalls in random bursts, none during the final phase.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
            repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        end
    end

    initial begin
        t_directed_row rows [$];
        t_setting      settings [$];
        t_seq_out      idle_rest;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_req         = '0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        calm           = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        requests_sent  = 0;
        ticks_sent     = 0;
        steps_advanced = 0;
        notes_started  = 0;
        cycle_count    = 0;

        // Predicted state after reset.
        foreach (step_mem[i]) step_mem[i] = '0;
        acc_q       = '0;
        pos_q       = '0;
        playing_q   = 1'b0;
        held_note_q = NOTE_REST;
        held_vel_q  = '0;
        held_x_q    = '0;
        held_y_q    = '0;
        held_z_q    = '0;
        sps_q       = SPS_RESET;
        swing_q     = SWING_RESET;
        count_q     = STEPS_RESET;

        // Directed table at the reset configuration; literal results where obvious.
        idle_rest = seq_result(0, -1, 0, 0, 0, 0, 0, 0);
        rows.push_back(t_directed_row'{tick_req(0, 0), 1'b1, idle_rest});
        rows.push_back(t_directed_row'{tick_req(16383, 65535), 1'b1, idle_rest});
        rows.push_back(t_directed_row'{step_req(0, 1, 60, 100, 65536, 1, 2, 3), 1'b1,
                                       idle_rest});
        rows.push_back(t_directed_row'{step_req(1, 1, 127, 127, 0, 255, 255, 255), 1'b1,
                                       idle_rest});
        rows.push_back(t_directed_row'{step_req(2, 1, -1, 127, 65536, 0, 0, 0), 1'b1,
                                       idle_rest});
        rows.push_back(t_directed_row'{step_req(3, 0, 5, 64, 65536, 9, 9, 9), 1'b1,
                                       idle_rest});
        rows.push_back(t_directed_row'{step_req(63, 1, 0, 0, 131071, 255, 0, 255), 1'b1,
                                       idle_rest});
        rows.push_back(t_directed_row'{ctl_req(CMD_SPARE_C, 63), 1'b1, idle_rest});
        rows.push_back(t_directed_row'{ctl_req(CMD_SETPOS, 63), 1'b1,
                                       seq_result(0, -1, 0, 0, 0, 0, 15, 0)});
        rows.push_back(t_directed_row'{ctl_req(CMD_START, 0), 1'b1,
                                       seq_result(0, -1, 0, 0, 0, 0, 0, 1)});
        rows.push_back(t_directed_row'{tick_req(8192, 0), 1'b1,
                                       seq_result(0, -1, 0, 0, 0, 0, 0, 1)});
        rows.push_back(t_directed_row'{tick_req(16383, 65535), 1'b1,
                                       seq_result(1, 60, 100, 1, 2, 3, 1, 1)});
        rows.push_back(t_directed_row'{tick_req(0, 0), 1'b1,
                                       seq_result(0, -1, 100, 1, 2, 3, 2, 1)});
        rows.push_back(t_directed_row'{tick_req(16383, 0), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{tick_req(0, 0), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{tick_req(100, 32768), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{ctl_req(CMD_SPARE_A, 0), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{ctl_req(CMD_SPARE_B, 21), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{ctl_req(CMD_SETPOS, 63), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{tick_req(16383, 1), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{step_req(15, 1, 72, 90, 1, 10, 20, 30), 1'b0,
                                       idle_rest});
        rows.push_back(t_directed_row'{ctl_req(CMD_SETPOS, 15), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{tick_req(16383, 0), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{ctl_req(CMD_STOP, 0), 1'b0, idle_rest});
        rows.push_back(t_directed_row'{tick_req(16383, 0), 1'b0, idle_rest});

        // Register settings for the random phases, extremes included.
        settings.push_back(t_setting'{SPS_W'(40 << 8), 8'd0, 7'd16});
        settings.push_back(t_setting'{SPS_W'((40 << 8) + 77), 8'd255, 7'd64});
        settings.push_back(t_setting'{SPS_W'(0), 8'd128, 7'd1});
        settings.push_back(t_setting'{SPS_W'(1), 8'd255, 7'd0});
        settings.push_back(t_setting'{SPS_W'(268435455), 8'd255, 7'd127});
        settings.push_back(t_setting'{SPS_W'($urandom_range(256, 768000)),
                                      8'($urandom), 7'($urandom_range(1, 64))});
        settings.push_back(t_setting'{SPS_W'(5 << 8), 8'd200, 7'd3});
        settings.push_back(t_setting'{SPS_W'($urandom_range(0, 64000)),
                                      8'($urandom), 7'($urandom_range(0, 127))});

        // Synchronous reset, released on a falling clock edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) issue(rows[i].req, rows[i].has_lit, rows[i].lit);

        // Random phases: each starts playback, then mixes ticks with edits and control.
        foreach (settings[p]) begin
            apply_settings(settings[p]);
            if (p == settings.size() - 1) calm = 1'b1;
            issue(ctl_req(CMD_START, 0), 1'b0, idle_rest);
            repeat (ITEMS_PER_PHASE) issue(draw_request(), 1'b0, idle_rest);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d register settings: %0d ticks, %0d steps advanced,",
                 requests_sent, settings.size() + 1, ticks_sent, steps_advanced);
        $display("%0d notes started; %0d results checked, %0d field errors.",
                 notes_started, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("swing_step_sequencer: match");
        end else begin
            $display("swing_step_sequencer: mismatch");
        end
        $finish;
    end

endmodule
